// ----- design/gob_pkg.sv -----
`default_nettype none
package gob_pkg;

   localparam int COL_BITS   = 11;
   localparam int ROW_BITS   = 11;
   localparam int CHAN_BITS  = 8;
   localparam int NUM_CHANS  = 3;
   localparam int SIZE_BITS  = 12;
   localparam int POS_BITS   = 12;
   localparam int SPAN_BITS  = 13;
   localparam int QUO_BITS   = 8;
   localparam int ALPHA_BITS = 9;
   localparam int PROD_BITS  = 17;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = 9'd256;

   localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = 12'd640;
   localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = 12'd480;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   typedef logic [CHAN_BITS-1:0] chan_type;

   typedef struct packed {
      chan_type [NUM_CHANS-1:0] base;
      chan_type [NUM_CHANS-1:0] over;
   } pixel_type;

endpackage
`default_nettype wire

// ----- design/gob_req_if.sv -----
`default_nettype none
interface gob_req_if;
   logic       valid;
   logic       ready;
   logic [10:0] col;
   logic [10:0] row;
   logic [7:0] base_blue;
   logic [7:0] base_green;
   logic [7:0] base_red;
   logic [7:0] over_blue;
   logic [7:0] over_green;
   logic [7:0] over_red;

   modport source (
      output valid, col, row, base_blue, base_green, base_red,
             over_blue, over_green, over_red,
      input  ready
   );
   modport sink (
      input  valid, col, row, base_blue, base_green, base_red,
             over_blue, over_green, over_red,
      output ready
   );
endinterface
`default_nettype wire

// ----- design/gob_rsp_if.sv -----
`default_nettype none
interface gob_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_blue;
   logic [7:0] out_green;
   logic [7:0] out_red;
   logic       write_blue;
   logic       write_green;
   logic       write_red;

   modport source (
      output valid, out_blue, out_green, out_red, write_blue, write_green, write_red,
      input  ready
   );
   modport sink (
      input  valid, out_blue, out_green, out_red, write_blue, write_green, write_red,
      output ready
   );
endinterface
`default_nettype wire

// ----- design/gob_csr_if.sv -----
`default_nettype none
interface gob_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [11:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface
`default_nettype wire

// ----- design/gob_div_stage.sv -----
`default_nettype none
// Two steps of restoring division: each step doubles the partial remainder
// and subtracts the divisor when it fits, producing one quotient bit.
module gob_div_stage
   import gob_pkg::*;
(
   input  wire logic [SPAN_BITS-1:0] rem_i,
   input  wire logic [SPAN_BITS-1:0] span_i,
   input  wire logic [QUO_BITS-1:0]  quo_i,
   output logic [SPAN_BITS-1:0]      rem_o,
   output logic [QUO_BITS-1:0]       quo_o
);

   logic [SPAN_BITS:0]   dbl1;
   logic [SPAN_BITS:0]   dbl2;
   logic [SPAN_BITS-1:0] mid;
   logic                 bit1;
   logic                 bit2;

   always_comb begin
      dbl1 = {rem_i, 1'b0};
      bit1 = (dbl1 >= {1'b0, span_i});
      mid  = bit1 ? SPAN_BITS'(dbl1 - {1'b0, span_i}) : SPAN_BITS'(dbl1);
      dbl2 = {mid, 1'b0};
      bit2 = (dbl2 >= {1'b0, span_i});
      rem_o = bit2 ? SPAN_BITS'(dbl2 - {1'b0, span_i}) : SPAN_BITS'(dbl2);
      quo_o = {quo_i[QUO_BITS-3:0], bit1, bit2};
   end

endmodule
`default_nettype wire

// ----- design/gradient_overlay_blend_top.sv -----
// Gradient overlay blend.
// Requests arrive on req_ch: pixel column and row plus three base and three
// overlay channels. Each request yields exactly one response on rsp_ch with
// the three output channels and their write flags. A channel whose overlay
// is zero passes the base value with its write flag clear.
// csr_ch writes frame_width (index 0) and frame_height (index 1); it is
// always ready and should be written only while no requests are in flight.
// Values above MAX_WIDTH / MAX_HEIGHT are clamped; other indexes are ignored.
// Throughput is one request per cycle while rsp_ch is ready. From acceptance
// to the response appearing on rsp_ch, one stage forms the diagonal position
// and span, four stages each produce two bits of the 8-bit opacity quotient,
// one stage forms the products and the last stage adds them into the output
// register. Each stage has its own valid bit and holds only when its
// successor is full and stalled, so a stalled receiver fills the bubbles
// before req_ch.ready drops. Synchronous reset empties the pipeline and
// restores frame_width to 640 and frame_height to 480.
`default_nettype none
module gradient_overlay_blend_top
   import gob_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire logic clock,
   input  wire logic reset,
   gob_req_if.sink   req_ch,
   gob_rsp_if.source rsp_ch,
   gob_csr_if.sink   csr_ch
);

   localparam int NUM_STAGES = 7;
   localparam int DIV_STAGES = 4;
   localparam logic [SIZE_BITS+1:0] MAX_W = (SIZE_BITS+2)'(MAX_WIDTH);
   localparam logic [SIZE_BITS+1:0] MAX_H = (SIZE_BITS+2)'(MAX_HEIGHT);

   // Configuration registers.
   logic [SIZE_BITS-1:0] width_ff, width_in;
   logic [SIZE_BITS-1:0] height_ff, height_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_FRAME_WIDTH: begin
               width_in = ({2'b00, csr_ch.data} > MAX_W) ? SIZE_BITS'(MAX_WIDTH)
                                                         : csr_ch.data;
            end
            CSR_FRAME_HEIGHT: begin
               height_in = ({2'b00, csr_ch.data} > MAX_H) ? SIZE_BITS'(MAX_HEIGHT)
                                                          : csr_ch.data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Pipeline flow control: stage k loads when it is empty or drains.
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES:0]   adv;

   always_comb begin
      adv[NUM_STAGES] = rsp_ch.ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         adv[k] = ~valid_ff[k] | adv[k+1];
      end
   end

   assign req_ch.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_ch.valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // Stage 0: diagonal position against the frame span.
   logic [POS_BITS-1:0]  pos;
   logic [SPAN_BITS-1:0] span;
   logic                 sat;
   pixel_type            pix_in;

   always_comb begin
      pos  = POS_BITS'(req_ch.col) + POS_BITS'(req_ch.row);
      span = SPAN_BITS'(width_ff) + SPAN_BITS'(height_ff);
      sat  = (SPAN_BITS'(pos) >= span);
      pix_in.base[0] = req_ch.base_blue;
      pix_in.base[1] = req_ch.base_green;
      pix_in.base[2] = req_ch.base_red;
      pix_in.over[0] = req_ch.over_blue;
      pix_in.over[1] = req_ch.over_green;
      pix_in.over[2] = req_ch.over_red;
   end

   // Stages 0 to 4 carry the division state; stage 0 holds the dividend.
   logic [SPAN_BITS-1:0] rem_ff  [DIV_STAGES+1];
   logic [SPAN_BITS-1:0] span_ff [DIV_STAGES+1];
   logic [QUO_BITS-1:0]  quo_ff  [DIV_STAGES+1];
   logic                 sat_ff  [DIV_STAGES+1];
   pixel_type            pix_ff  [DIV_STAGES+1];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         // A saturated pixel divides zero by a nonzero span, so its quotient
         // stays zero even for an empty frame.
         rem_ff[0]  <= sat ? '0 : SPAN_BITS'(pos);
         span_ff[0] <= sat ? '1 : span;
         quo_ff[0]  <= '0;
         sat_ff[0]  <= sat;
         pix_ff[0]  <= pix_in;
      end
   end

   for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
      logic [SPAN_BITS-1:0] rem_in;
      logic [QUO_BITS-1:0]  quo_in;

      gob_div_stage u_div (
         .rem_i  (rem_ff[g-1]),
         .span_i (span_ff[g-1]),
         .quo_i  (quo_ff[g-1]),
         .rem_o  (rem_in),
         .quo_o  (quo_in)
      );

      always_ff @(posedge clock) begin
         if (adv[g]) begin
            rem_ff[g]  <= rem_in;
            span_ff[g] <= span_ff[g-1];
            quo_ff[g]  <= quo_in;
            sat_ff[g]  <= sat_ff[g-1];
            pix_ff[g]  <= pix_ff[g-1];
         end
      end
   end

   // Stage 5: opacity weighted products.
   logic [ALPHA_BITS-1:0] alpha;
   logic [ALPHA_BITS-1:0] keep;
   logic [PROD_BITS-1:0]  prod_base_in [NUM_CHANS];
   logic [PROD_BITS-1:0]  prod_over_in [NUM_CHANS];
   logic [PROD_BITS-1:0]  prod_base_ff [NUM_CHANS];
   logic [PROD_BITS-1:0]  prod_over_ff [NUM_CHANS];
   pixel_type             pix_p_ff;

   always_comb begin
      alpha = sat_ff[DIV_STAGES] ? ALPHA_ONE : ALPHA_BITS'(quo_ff[DIV_STAGES]);
      keep  = ALPHA_ONE - alpha;
      for (int c = 0; c < NUM_CHANS; c++) begin
         prod_base_in[c] = PROD_BITS'(keep) * PROD_BITS'(pix_ff[DIV_STAGES].base[c]);
         prod_over_in[c] = PROD_BITS'(alpha) * PROD_BITS'(pix_ff[DIV_STAGES].over[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[DIV_STAGES+1]) begin
         prod_base_ff <= prod_base_in;
         prod_over_ff <= prod_over_in;
         pix_p_ff     <= pix_ff[DIV_STAGES];
      end
   end

   // Stage 6: sum of the two scaled terms, or the base for a transparent channel.
   chan_type [NUM_CHANS-1:0] out_in, out_ff;
   logic     [NUM_CHANS-1:0] wr_in, wr_ff;

   always_comb begin
      for (int c = 0; c < NUM_CHANS; c++) begin
         wr_in[c]  = (pix_p_ff.over[c] != '0);
         out_in[c] = wr_in[c] ? CHAN_BITS'(prod_base_ff[c][PROD_BITS-1:8]
                                           + prod_over_ff[c][PROD_BITS-1:8])
                              : pix_p_ff.base[c];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NUM_STAGES-1]) begin
         out_ff <= out_in;
         wr_ff  <= wr_in;
      end
   end

   assign rsp_ch.valid       = valid_ff[NUM_STAGES-1];
   assign rsp_ch.out_blue    = out_ff[0];
   assign rsp_ch.out_green   = out_ff[1];
   assign rsp_ch.out_red     = out_ff[2];
   assign rsp_ch.write_blue  = wr_ff[0];
   assign rsp_ch.write_green = wr_ff[1];
   assign rsp_ch.write_red   = wr_ff[2];

   // Input back-pressure appears only once every stage holds a request.
   assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (&valid_ff))
      else $error("input stalled while the pipeline has an empty stage");

   // A saturated pixel must leave the divider with a zero quotient.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[DIV_STAGES] && sat_ff[DIV_STAGES]) |-> (quo_ff[DIV_STAGES] == '0))
      else $error("quotient nonzero for a pixel outside the frame");

   // A request moving out of the product stage must land in the output register.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NUM_STAGES-2] && adv[NUM_STAGES-1]) |=> valid_ff[NUM_STAGES-1])
      else $error("request lost between product and output stages");

endmodule
`default_nettype wire
